// File: hdl/ohlcv_pkg.sv
package ohlcv_pkg;

  localparam int TIME_W  = 63;
  localparam int PRICE_W = 64;
  localparam int SYM_W   = 32;
  localparam int SIZE_W  = 32;
  localparam int COUNT_W = 16;
  localparam int UNIT_W  = 47;
  localparam int DIV_W   = 64;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_BAR_UNIT    = 2'd0;
  localparam logic [1:0] REG_BAR_COUNT   = 2'd1;
  localparam logic [1:0] REG_CUTOFF_TIME = 2'd2;

  // Nanoseconds per bar unit: second, minute, hour, day
  localparam logic [UNIT_W-1:0] UNIT_NS [4] = '{
    47'd1000000000, 47'd60000000000, 47'd3600000000000, 47'd86400000000000
  };

  typedef struct packed {
    logic [TIME_W-1:0]  recv_time;
    logic [SYM_W-1:0]   symbol;
    logic [PRICE_W-1:0] trade_price;
    logic [PRICE_W-1:0] bid;
    logic [SIZE_W-1:0]  trade_size;
    logic               end_of_batch;
  } tick_t;

  typedef struct packed {
    logic [TIME_W-1:0]  open_time;
    logic [TIME_W-1:0]  close_time;
    logic [SYM_W-1:0]   bar_symbol;
    logic [PRICE_W-1:0] open_price;
    logic [PRICE_W-1:0] high_price;
    logic [PRICE_W-1:0] low_price;
    logic [PRICE_W-1:0] close_price;
    logic [PRICE_W-1:0] vwap;
    logic [PRICE_W-1:0] volume;
    logic [31:0]        tick_total;
    logic               batch_final;
  } bar_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_VDIV, ST_VWAIT, ST_EMIT, ST_ADIV, ST_AWAIT,
    ST_UPDATE, ST_MUL_LO, ST_MUL_HI, ST_MUL_ADD, ST_FINISH
  } state_t;

  // Why a bar is being emitted
  typedef enum logic [1:0] {
    CTX_CUTOFF, CTX_ROLL, CTX_EOB
  } ctx_t;

endpackage

// File: hdl/ohlcv_div.sv
module ohlcv_div import ohlcv_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [DIV_W-1:0] quot,
  output logic [DIV_W-1:0] rem
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] den_q;
  logic [DIV_W:0]   rem_shift;
  logic [DIV_W:0]   diff;

  // One quotient bit per cycle, restoring
  assign rem_shift = {rem, quot[DIV_W-1]};
  assign diff      = rem_shift - {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_q <= den;
      quot  <= num;
      rem   <= '0;
    end else if (busy) begin
      if (!diff[DIV_W]) begin
        rem <= diff[DIV_W-1:0];
      end else begin
        rem <= rem_shift[DIV_W-1:0];
      end
      quot <= {quot[DIV_W-2:0], ~diff[DIV_W]};
    end
  end

endmodule

// File: hdl/ohlcv_time_bar_aggregator_core.sv
// Ticks past the cutoff are ignored; a tick that adds volume runs a multiply in two
// 32x32 halves (MUL_LO, MUL_HI, MUL_ADD). Window alignment and the VWAP of each emitted
// bar run on the shared 64-step divider (no VWAP divide with no volume). One tick at a
// time; a stalled output holds the emit state.
// Reset (rst, synchronous) clears batch and bar state; unit second, count one, max cutoff.
module ohlcv_time_bar_aggregator_core import ohlcv_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tick_t               in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bar_t                out_data,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [TIME_W-1:0]   cfg_data
);

  state_t state, state_next;
  ctx_t   ctx;
  tick_t  tick;

  logic [1:0]         bar_unit;
  logic [COUNT_W-1:0] bar_count;
  logic [TIME_W-1:0]  cutoff_time;
  logic [TIME_W-1:0]  bar_len;

  logic [TIME_W-1:0]  window_start;
  logic               batch_started, bar_live, past_cutoff;
  logic [SYM_W-1:0]   held_symbol;
  logic [PRICE_W-1:0] first_price, max_price, min_price, latest_price;
  logic [PRICE_W-1:0] price_volume_sum, volume_sum;
  logic [31:0]        tick_count;
  logic [PRICE_W-1:0] mul_q, vwap_q;
  logic               vneg;

  logic [PRICE_W-1:0] px;
  logic               over_cutoff, roll, out_free, size_nz, vol_zero;
  logic [COUNT_W-1:0] count_eff;
  logic [31:0]        mul_a;
  logic               div_start, div_busy, div_done;
  logic [DIV_W-1:0]   div_num, div_den, div_quot, div_rem;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bar_unit    <= '0;
      bar_count   <= COUNT_W'(1);
      cutoff_time <= '1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BAR_UNIT:    bar_unit    <= cfg_data[1:0];
        REG_BAR_COUNT:   bar_count   <= cfg_data[COUNT_W-1:0];
        REG_CUTOFF_TIME: cutoff_time <= cfg_data;
        default: ;
      endcase
    end
  end

  // Bar length in ns, registered off the config registers
  assign count_eff = (bar_count == '0) ? COUNT_W'(1) : bar_count;
  always_ff @(posedge clk) begin
    bar_len <= TIME_W'(count_eff * UNIT_NS[bar_unit]);
  end

  assign px          = ($signed(tick.trade_price) > 0) ? tick.trade_price : tick.bid;
  assign over_cutoff = tick.recv_time > cutoff_time;
  assign roll        = {1'b0, tick.recv_time} >= ({1'b0, window_start} + {1'b0, bar_len});
  assign out_free    = !out_valid || !out_stall;
  assign size_nz     = tick.trade_size != '0;
  assign vol_zero    = volume_sum == '0;
  assign in_stall    = state != ST_IDLE;

  // Shared divider operands
  always_comb begin
    if (state == ST_ADIV) begin
      div_num = {1'b0, tick.recv_time};
      div_den = {1'b0, bar_len};
    end else begin
      div_num = price_volume_sum[PRICE_W-1] ? -price_volume_sum : price_volume_sum;
      div_den = volume_sum[PRICE_W-1] ? -volume_sum : volume_sum;
    end
  end

  assign div_start = (state == ST_ADIV) || (state == ST_VDIV && !vol_zero);

  ohlcv_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .done (div_done),
    .quot (div_quot),
    .rem  (div_rem)
  );

  // Shared 32x32 multiplier, registered
  assign mul_a = (state == ST_MUL_HI) ? px[63:32] : px[31:0];
  always_ff @(posedge clk) begin
    mul_q <= mul_a * tick.trade_size;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_CHECK;
      ST_CHECK: begin
        if (past_cutoff)        state_next = ST_IDLE;
        else if (over_cutoff)   state_next = bar_live ? ST_VDIV : ST_IDLE;
        else if (!batch_started) state_next = ST_ADIV;
        else if (roll)          state_next = bar_live ? ST_VDIV : ST_ADIV;
        else                    state_next = ST_UPDATE;
      end
      ST_VDIV:   state_next = vol_zero ? ST_EMIT : ST_VWAIT;
      ST_VWAIT:  if (div_done) state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_next = (ctx == CTX_ROLL) ? ST_ADIV : ST_IDLE;
      end
      ST_ADIV:   state_next = ST_AWAIT;
      ST_AWAIT:  if (div_done) state_next = ST_UPDATE;
      ST_UPDATE: state_next = size_nz ? ST_MUL_LO : ST_FINISH;
      ST_MUL_LO: state_next = ST_MUL_HI;
      ST_MUL_HI: state_next = ST_MUL_ADD;
      ST_MUL_ADD: state_next = ST_FINISH;
      ST_FINISH: state_next = tick.end_of_batch ? ST_VDIV : ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      batch_started    <= 1'b0;
      bar_live         <= 1'b0;
      past_cutoff      <= 1'b0;
      out_valid        <= 1'b0;
      ctx              <= CTX_EOB;
      window_start     <= '0;
      price_volume_sum <= '0;
      volume_sum       <= '0;
      tick_count       <= '0;
    end else begin
      // Load the output register on emit, drop it once taken
      if (state == ST_EMIT && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        ST_CHECK: begin
          if (past_cutoff) begin
            if (tick.end_of_batch) begin
              batch_started <= 1'b0;
              past_cutoff   <= 1'b0;
              bar_live      <= 1'b0;
              price_volume_sum <= '0;
              volume_sum    <= '0;
            end
          end else if (over_cutoff) begin
            ctx <= CTX_CUTOFF;
            // End of batch with no bar open closes the batch right here
            if (!bar_live && tick.end_of_batch) begin
              batch_started <= 1'b0;
              price_volume_sum <= '0;
              volume_sum    <= '0;
            end else begin
              past_cutoff <= 1'b1;
            end
          end else if (!batch_started) begin
            batch_started <= 1'b1;
          end else begin
            ctx <= CTX_ROLL;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            bar_live         <= 1'b0;
            price_volume_sum <= '0;
            volume_sum       <= '0;
            // Close the batch after a final flush
            if (ctx == CTX_EOB || (ctx == CTX_CUTOFF && tick.end_of_batch)) begin
              batch_started <= 1'b0;
              past_cutoff   <= 1'b0;
            end
          end
        end
        ST_AWAIT: if (div_done) window_start <= tick.recv_time - div_rem[TIME_W-1:0];
        ST_UPDATE: begin
          bar_live   <= 1'b1;
          volume_sum <= volume_sum + {32'b0, tick.trade_size};
          if (!bar_live) begin
            tick_count <= 32'd1;
          end else if (tick_count != '1) begin
            tick_count <= tick_count + 1'b1;
          end
        end
        ST_MUL_HI:  price_volume_sum <= price_volume_sum + mul_q;
        ST_MUL_ADD: price_volume_sum <= price_volume_sum + {mul_q[31:0], 32'b0};
        ST_FINISH:  ctx <= CTX_EOB;
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) tick <= in_data;
    if (state == ST_UPDATE) begin
      latest_price <= px;
      if (!bar_live) begin
        held_symbol <= tick.symbol;
        first_price <= px;
        max_price   <= px;
        min_price   <= px;
      end else begin
        if ($signed(px) > $signed(max_price)) max_price <= px;
        if ($signed(px) < $signed(min_price)) min_price <= px;
      end
    end
    if (state == ST_VDIV) begin
      vneg   <= price_volume_sum[PRICE_W-1] ^ volume_sum[PRICE_W-1];
      vwap_q <= latest_price;
    end
    if (state == ST_VWAIT && div_done) vwap_q <= vneg ? -div_quot : div_quot;
    if (state == ST_EMIT && out_free) begin
      out_data.open_time   <= window_start;
      out_data.close_time  <= window_start + bar_len - TIME_W'(1);
      out_data.bar_symbol  <= held_symbol;
      out_data.open_price  <= first_price;
      out_data.high_price  <= max_price;
      out_data.low_price   <= min_price;
      out_data.close_price <= latest_price;
      out_data.vwap        <= vwap_q;
      out_data.volume      <= volume_sum;
      out_data.tick_total  <= tick_count;
      out_data.batch_final <= (ctx == CTX_EOB) || (ctx == CTX_CUTOFF && tick.end_of_batch);
    end
  end

  a_div_owned: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (state == ST_VWAIT || state == ST_AWAIT))
    else $error("divider busy outside a wait state");

  a_open_in_batch: assert property (@(posedge clk) disable iff (rst)
    bar_live |-> batch_started)
    else $error("bar open outside a batch");

  a_cutoff_closed: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && past_cutoff) |-> !bar_live)
    else $error("bar still open past cutoff");

endmodule
